>>> rtl/tql_pkg.sv
// Shared constants, codes and interface types of the Q-learning update block.
// Used by tql_arith and tabular_q_learning_update; depends on nothing else.
`timescale 1ns / 1ps

package tql_pkg;

	localparam int NUM_STATES = 16;
	localparam int NUM_MOVES  = 8;

	localparam int ACT_W   = 2;
	localparam int STATE_W = 4;
	localparam int MOVE_W  = 3;
	localparam int Q_W     = 32;
	localparam int RATE_W  = 16;
	localparam int SHARE_W = 17;
	localparam int CFG_W   = 2;

	localparam int COL_W  = $clog2(NUM_MOVES);
	localparam int DEPTH  = NUM_STATES * NUM_MOVES;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	localparam logic [CFG_W-1:0] CFG_LEARN    = 2'd0;
	localparam logic [CFG_W-1:0] CFG_DISCOUNT = 2'd1;
	localparam logic [CFG_W-1:0] CFG_EXPLORE  = 2'd2;

	localparam logic [RATE_W-1:0] LEARN_RESET    = 16'd6554;
	localparam logic [RATE_W-1:0] DISCOUNT_RESET = 16'd62259;
	localparam logic [RATE_W-1:0] EXPLORE_RESET  = 16'd6554;

	localparam int ONE_Q16 = 65536;

	localparam int OTHER_DIV = NUM_MOVES - 1;
	localparam int DIV_SHIFT = 24;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam int RECIP     = (1 << DIV_SHIFT) / OTHER_DIV;

	typedef struct packed {
		logic                  start;
		logic signed [Q_W-1:0] old_val;
		logic signed [Q_W-1:0] row_max;
		logic signed [Q_W-1:0] reward;
	} tql_arith_req_t;

	typedef struct packed {
		logic                  done;
		logic signed [Q_W-1:0] value;
	} tql_arith_rsp_t;

endpackage

>>> rtl/tql_arith.sv
// Multi-cycle datapath of the learning update: target and blended entry value.
// One shared 18x32 multiplier over five steps; depends on tql_pkg.
`timescale 1ns / 1ps

module tql_arith (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tql_pkg::RATE_W-1:0]    learn_rate,
	input  logic [tql_pkg::RATE_W-1:0]    discount,
	input  tql_pkg::tql_arith_req_t       req,
	output tql_pkg::tql_arith_rsp_t       rsp
);
	import tql_pkg::*;

	localparam logic [2:0] STEP_MAX    = 3'd0;
	localparam logic [2:0] STEP_TARGET = 3'd1;
	localparam logic [2:0] STEP_OLD    = 3'd2;
	localparam logic [2:0] STEP_NEW    = 3'd3;
	localparam logic [2:0] STEP_SUM    = 3'd4;

	localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
	localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

	function automatic logic signed [Q_W-1:0] sat32(input logic signed [50:0] v);
		logic signed [Q_W-1:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7fffffff;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	logic                  busy_q;
	logic [2:0]            step_q;
	logic signed [Q_W-1:0] old_q;
	logic signed [Q_W-1:0] max_q;
	logic signed [Q_W-1:0] reward_q;
	logic signed [Q_W-1:0] target_q;
	logic signed [49:0]    prod_q;
	logic signed [50:0]    acc_q;

	logic signed [17:0]    mul_a;
	logic signed [Q_W-1:0] mul_b;
	logic signed [49:0]    prod_d;
	logic [16:0]           one_minus_lr;
	logic signed [49:0]    prod_rnd;
	logic signed [50:0]    target_sum;
	logic signed [50:0]    acc_sum;
	logic signed [50:0]    acc_rnd;

	assign one_minus_lr = 17'(ONE_Q16) - {1'b0, learn_rate};

	always_comb begin
		unique case (step_q)
			STEP_MAX: begin
				mul_a = {2'b00, discount};
				mul_b = max_q;
			end
			STEP_OLD: begin
				mul_a = {1'b0, one_minus_lr};
				mul_b = old_q;
			end
			default: begin
				mul_a = {2'b00, learn_rate};
				mul_b = target_q;
			end
		endcase
	end

	assign prod_d     = mul_a * mul_b;
	assign prod_rnd   = (prod_q + 50'sd32768) >>> 16;
	assign target_sum = {prod_rnd[49], prod_rnd} + {{19{reward_q[Q_W-1]}}, reward_q};
	assign acc_sum    = acc_q + {prod_q[49], prod_q};
	assign acc_rnd    = (acc_sum + 51'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_MAX;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= STEP_MAX;
		end else if (busy_q) begin
			if (step_q == STEP_SUM) begin
				busy_q <= 1'b0;
				step_q <= STEP_MAX;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			old_q    <= req.old_val;
			max_q    <= req.row_max;
			reward_q <= req.reward;
		end
		if (busy_q) begin
			unique case (step_q)
				STEP_MAX:    prod_q <= prod_d;
				STEP_TARGET: target_q <= sat32(target_sum);
				STEP_OLD:    prod_q <= prod_d;
				STEP_NEW: begin
					acc_q  <= {prod_q[49], prod_q};
					prod_q <= prod_d;
				end
				default: ;
			endcase
		end
	end

	assign rsp.done  = busy_q && (step_q == STEP_SUM);
	assign rsp.value = sat32(acc_rnd);

endmodule

>>> rtl/tabular_q_learning_update.sv
// Top level of the tabular Q-learning update block: Q table memory, item sequencer,
// configuration registers and output register. Depends on tql_pkg and tql_arith.
`timescale 1ns / 1ps

// The block holds a NUM_STATES by NUM_MOVES table of signed Q16.16 values in one
// synchronous memory with a single read port and a single write port, and handles
// one item at a time. A learning update runs a scan of the next row for its maximum,
// a read of the old entry, five steps of the shared multiplier, the write back and a
// second scan for the greedy move. The row scans go through the one memory read
// port. A new item is taken while the previous result still waits in the output
// register. The table is undefined until written; configuration registers are
// written through the cfg channel; the user must write them only while idle, as
// the block itself does not enforce it.
module tabular_q_learning_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tql_pkg::CFG_W-1:0]         cfg_index,
	input  logic [tql_pkg::RATE_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tql_pkg::ACT_W-1:0]         action,
	input  logic [tql_pkg::STATE_W-1:0]       prev_state,
	input  logic [tql_pkg::MOVE_W-1:0]        chosen_move,
	input  logic [tql_pkg::STATE_W-1:0]       next_state,
	input  logic signed [tql_pkg::Q_W-1:0]    reward_value,
	input  logic signed [tql_pkg::Q_W-1:0]    q_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tql_pkg::Q_W-1:0]    q_result,
	output logic [tql_pkg::MOVE_W-1:0]        greedy_move,
	output logic [tql_pkg::SHARE_W-1:0]       greedy_share,
	output logic [tql_pkg::RATE_W-1:0]        other_share
);
	import tql_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SCAN     = 4'd1;
	localparam logic [3:0] ST_SCAN_END = 4'd2;
	localparam logic [3:0] ST_RD       = 4'd3;
	localparam logic [3:0] ST_RD_WAIT  = 4'd4;
	localparam logic [3:0] ST_ARITH    = 4'd5;
	localparam logic [3:0] ST_WRITE    = 4'd6;
	localparam logic [3:0] ST_FINISH   = 4'd7;

	function automatic logic [ADDR_W-1:0] entry_addr(input int row, input int col);
		return ADDR_W'(row * NUM_MOVES + col);
	endfunction

	logic [3:0]             state_q;
	logic [COL_W-1:0]       cnt_q;
	logic                   scan_max_q;
	logic                   scan_v_s1;
	logic [COL_W-1:0]       scan_col_s1;
	logic                   out_valid_q;

	logic [RATE_W-1:0]      learn_q;
	logic [RATE_W-1:0]      discount_q;
	logic [RATE_W-1:0]      explore_q;

	logic [ACT_W-1:0]       kind_q;
	logic [STATE_W-1:0]     prev_q;
	logic [MOVE_W-1:0]      move_q;
	logic [STATE_W-1:0]     next_q;
	logic signed [Q_W-1:0]  reward_q;
	logic                   inrange_q;
	logic                   next_ok_q;
	logic signed [Q_W-1:0]  result_q;
	logic signed [Q_W-1:0]  best_val_q;
	logic [COL_W-1:0]       best_idx_q;

	logic signed [Q_W-1:0]  q_result_q;
	logic [MOVE_W-1:0]      greedy_move_q;
	logic [SHARE_W-1:0]     greedy_share_q;
	logic [RATE_W-1:0]      other_share_q;

	logic [RATE_W-1:0]      div_q0_s1;
	logic [RATE_W-1:0]      div_eps_s1;
	logic [RATE_W-1:0]      other_q;
	logic [RATE_W+RECIP_W-1:0] div_prod;
	logic [RATE_W:0]        div_rem;

	logic signed [Q_W-1:0]  mem [DEPTH];
	logic signed [Q_W-1:0]  rd_data_q;
	logic                   mem_re;
	logic                   mem_we;
	logic [ADDR_W-1:0]      rd_addr;
	logic [ADDR_W-1:0]      wr_addr;

	logic                   accept;
	logic                   inrange_d;
	logic                   next_ok_d;
	logic                   next_ok_sel;
	logic [3:0]             arg_state_d;
	logic [3:0]             idle_next;
	logic                   idle_scan_max;
	logic                   scan_last;
	logic                   out_load;

	tql_arith_req_t         arith_req;
	tql_arith_rsp_t         arith_rsp;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign inrange_d = (int'(prev_state) < NUM_STATES) && (int'(chosen_move) < NUM_MOVES);
	assign next_ok_d = (int'(next_state) < NUM_STATES);
	assign next_ok_sel = (state_q == ST_IDLE) ? next_ok_d : next_ok_q;
	assign arg_state_d = next_ok_sel ? ST_SCAN : ST_FINISH;
	assign scan_last = (cnt_q == COL_W'(NUM_MOVES - 1));
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		idle_next     = arg_state_d;
		idle_scan_max = 1'b0;
		if (inrange_d) begin
			unique case (action)
				ACT_UPDATE: begin
					idle_scan_max = next_ok_d;
					idle_next     = next_ok_d ? ST_SCAN : ST_RD;
				end
				ACT_WRITE: idle_next = ST_WRITE;
				ACT_READ:  idle_next = ST_RD;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q    <= LEARN_RESET;
			discount_q <= DISCOUNT_RESET;
			explore_q  <= EXPLORE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEARN:    learn_q <= cfg_data;
				CFG_DISCOUNT: discount_q <= cfg_data;
				CFG_EXPLORE:  explore_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The share of each other move is a reciprocal multiply with a single correction.
	assign div_prod = {{RECIP_W{1'b0}}, explore_q} * {{RATE_W{1'b0}}, RECIP_W'(RECIP)};
	assign div_rem  = {1'b0, div_eps_s1} - (RATE_W + 1)'(div_q0_s1 * OTHER_DIV);

	always_ff @(posedge clk) begin
		div_q0_s1  <= div_prod[DIV_SHIFT+RATE_W-1:DIV_SHIFT];
		div_eps_s1 <= explore_q;
		other_q    <= (div_rem >= (RATE_W + 1)'(OTHER_DIV)) ? div_q0_s1 + 1'b1 : div_q0_s1;
	end

	assign mem_re  = (state_q == ST_SCAN) || (state_q == ST_RD);
	assign mem_we  = (state_q == ST_WRITE);
	assign wr_addr = entry_addr(int'(prev_q), int'(move_q));
	assign rd_addr = (state_q == ST_SCAN) ? entry_addr(int'(next_q), int'(cnt_q)) : wr_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= result_q;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign arith_req.start   = (state_q == ST_RD_WAIT) && (kind_q == ACT_UPDATE);
	assign arith_req.old_val = rd_data_q;
	assign arith_req.row_max = best_val_q;
	assign arith_req.reward  = reward_q;

	tql_arith u_arith (
		.clk        (clk),
		.arst_n     (arst_n),
		.learn_rate (learn_q),
		.discount   (discount_q),
		.req        (arith_req),
		.rsp        (arith_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scan_max_q  <= 1'b0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == ST_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						scan_max_q <= idle_scan_max;
						state_q    <= idle_next;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN_END;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN_END: begin
					state_q <= scan_max_q ? ST_RD : ST_FINISH;
				end
				ST_RD: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					if (kind_q == ACT_UPDATE) begin
						state_q <= ST_ARITH;
					end else begin
						scan_max_q <= 1'b0;
						state_q    <= arg_state_d;
					end
				end
				ST_ARITH: begin
					if (arith_rsp.done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					scan_max_q <= 1'b0;
					state_q    <= arg_state_d;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		scan_col_s1 <= cnt_q;
		if (accept) begin
			kind_q     <= action;
			prev_q     <= prev_state;
			move_q     <= chosen_move;
			next_q     <= next_state;
			reward_q   <= reward_value;
			inrange_q  <= inrange_d;
			next_ok_q  <= next_ok_d;
			result_q   <= (action == ACT_WRITE && inrange_d) ? q_value : '0;
			best_val_q <= '0;
			best_idx_q <= '0;
		end
		if (scan_v_s1 && (scan_col_s1 == '0 || rd_data_q > best_val_q)) begin
			best_val_q <= rd_data_q;
			best_idx_q <= scan_col_s1;
		end
		if (state_q == ST_RD_WAIT && kind_q == ACT_READ) begin
			result_q <= rd_data_q;
		end
		if (state_q == ST_ARITH && arith_rsp.done) begin
			result_q <= arith_rsp.value;
		end
		if (out_load) begin
			q_result_q     <= result_q;
			greedy_move_q  <= MOVE_W'(best_idx_q);
			greedy_share_q <= SHARE_W'(ONE_Q16) - {1'b0, explore_q};
			other_share_q  <= other_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign q_result     = q_result_q;
	assign greedy_move  = greedy_move_q;
	assign greedy_share = greedy_share_q;
	assign other_share  = other_share_q;

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> inrange_q)
		else $error("table write for an entry out of range");

	a_arith_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		arith_rsp.done |-> (state_q == ST_ARITH))
		else $error("arithmetic result outside the update step");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after an accepted beat");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && $past(state_q) != ST_SCAN) |-> (cnt_q == '0))
		else $error("row scan started at a nonzero column");

	a_finish_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not loaded into a free output register");

endmodule
